FILE: rtl/boxf_pkg.sv
package boxf_pkg;

    localparam int PIX_BITS      = 8;
    localparam int FW_BITS       = 11;
    localparam int FH_BITS       = 13;
    localparam logic [FW_BITS-1:0] FW_RESET = 11'd640;
    localparam logic [FH_BITS-1:0] FH_RESET = 13'd480;
    localparam int HEIGHT_LIMIT  = 4096;
    localparam int ROW_BITS      = 13;
    localparam int HL_BITS       = 12;
    localparam int COLSUM_BITS   = 10;
    localparam int SUM_BITS      = 12;
    localparam int RECIP_BITS    = 17;
    localparam int RECIP_SHIFT   = 16;
    localparam int APB_DATA_BITS = 32;
    localparam int APB_ADDR_BITS = 3;
    localparam int OP_DEPTH      = 4;
    localparam int OUT_DEPTH     = 8;

    typedef enum logic [0:0] {
        REG_FRAME_WIDTH  = 1'b0,
        REG_FRAME_HEIGHT = 1'b1
    } t_reg_idx;

    typedef struct packed {
        logic out_valid;
        logic use_top;
        logic use_bot;
        logic use_left;
        logic use_right;
        logic last;
    } t_op_ctl;

    // Reciprocal of the neighbor count, scaled by 2**RECIP_SHIFT and rounded up.
    // Exact truncated quotients for every sum the window can produce.
    function automatic logic [RECIP_BITS-1:0] recip(input logic [1:0] n_rows,
                                                    input logic [1:0] n_cols);
        logic [3:0] cnt;
        logic [RECIP_BITS-1:0] m;
        cnt = {2'b00, n_rows} * {2'b00, n_cols};
        unique case (cnt)
            4'd2:    m = 17'd32768;
            4'd3:    m = 17'd21846;
            4'd4:    m = 17'd16384;
            4'd6:    m = 17'd10923;
            4'd9:    m = 17'd7282;
            default: m = 17'd65536;
        endcase
        return m;
    endfunction

endpackage

FILE: rtl/boxf_ram.sv
module boxf_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: rtl/boxf_fifo.sv
module boxf_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_push,
    input  logic [WIDTH-1:0]           i_data,
    output logic                       o_full,
    input  logic                       i_pop,
    output logic [WIDTH-1:0]           o_data,
    output logic                       o_empty,
    output logic [$clog2(DEPTH+1)-1:0] o_count
);

    localparam int PW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNTW = $clog2(DEPTH+1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PW-1:0]    r_wr_ptr, r_rd_ptr, n_wr_ptr, n_rd_ptr;
    logic [CNTW-1:0]  r_count, n_count;
    logic             do_push, do_pop;

    assign o_full  = (r_count == CNTW'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_count = r_count;
    assign o_data  = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_comb begin
        n_wr_ptr = (r_wr_ptr == PW'(DEPTH-1)) ? '0 : r_wr_ptr + PW'(1);
        n_rd_ptr = (r_rd_ptr == PW'(DEPTH-1)) ? '0 : r_rd_ptr + PW'(1);
        n_count  = r_count;
        if (do_push && !do_pop) begin
            n_count = r_count + CNTW'(1);
        end else if (do_pop && !do_push) begin
            n_count = r_count - CNTW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= n_wr_ptr;
            end
            if (do_pop) begin
                r_rd_ptr <= n_rd_ptr;
            end
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

FILE: rtl/boxf_front.sv
module boxf_front #(
    parameter int COL_BITS = 10
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_restart,
    input  logic [COL_BITS-1:0]           i_col_last,
    input  logic [boxf_pkg::HL_BITS-1:0]  i_row_last,
    input  logic                          i_push,
    input  logic                          i_req_type,
    input  logic [boxf_pkg::PIX_BITS-1:0] i_pixel_in,
    output logic                          o_full,
    output logic                          o_op_push,
    output logic [COL_BITS-1:0]           o_op_addr,
    output logic [boxf_pkg::PIX_BITS-1:0] o_op_pix,
    output boxf_pkg::t_op_ctl             o_op_ctl,
    input  logic                          i_op_full
);

    localparam int RB = boxf_pkg::ROW_BITS;
    localparam int HB = boxf_pkg::HL_BITS;

    logic [COL_BITS-1:0] r_col, n_col, cc;
    logic [RB-1:0]       r_row, n_row, rc, row_last_ext;
    logic                r_extra, n_extra;
    logic                col_zero, row_ok, ctr_valid, drain_phase, accept, op_go, end_frame;
    boxf_pkg::t_op_ctl   ctl;

    always_comb begin
        row_last_ext = {1'b0, i_row_last};
        col_zero     = (r_col == '0);
        rc           = col_zero ? r_row - RB'(2) : r_row - RB'(1);
        row_ok       = col_zero ? (r_row >= RB'(2)) : (r_row != '0);
        ctr_valid    = row_ok && (rc <= row_last_ext);
        cc           = col_zero ? i_col_last : r_col - COL_BITS'(1);

        ctl.out_valid = ctr_valid;
        ctl.use_top   = (rc[HB-1:0] != '0);
        ctl.use_bot   = (rc[HB-1:0] < i_row_last);
        ctl.use_left  = (cc != '0);
        ctl.use_right = !col_zero && (cc < i_col_last);
        ctl.last      = ctr_valid && (rc[HB-1:0] == i_row_last) && (cc == i_col_last);

        drain_phase = (r_row > row_last_ext);
        o_full      = r_extra || i_op_full;
        accept      = i_push && !o_full;
        op_go       = r_extra ? !i_op_full : accept && (drain_phase || !i_req_type);

        if (r_col >= i_col_last) begin
            n_col = '0;
            n_row = r_row + RB'(1);
        end else begin
            n_col = r_col + COL_BITS'(1);
            n_row = r_row;
        end

        n_extra = r_extra;
        if (op_go && r_extra) begin
            n_extra = 1'b0;
        end else if (op_go && drain_phase && !ctr_valid) begin
            n_extra = 1'b1;
        end

        end_frame = op_go && drain_phase && (ctl.last || (r_extra && !ctr_valid));
    end

    assign o_op_push = op_go;
    assign o_op_addr = r_col;
    assign o_op_pix  = drain_phase ? '0 : i_pixel_in;
    assign o_op_ctl  = ctl;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_restart) begin
            r_col   <= '0;
            r_row   <= '0;
            r_extra <= 1'b0;
        end else if (end_frame) begin
            r_col   <= '0;
            r_row   <= '0;
            r_extra <= 1'b0;
        end else if (op_go) begin
            r_col   <= n_col;
            r_row   <= n_row;
            r_extra <= n_extra;
        end
    end

`ifndef SYNTHESIS
    a_last_ends_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_op_push && o_op_ctl.last |=> (r_col == '0) && (r_row == '0))
        else $error("Frame position did not return to the origin after the last word.");

    a_extra_only_draining: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_extra |-> drain_phase)
        else $error("Second advance pending outside the drain phase.");
`endif

endmodule

FILE: rtl/boxf_back.sv
module boxf_back #(
    parameter int LINE_DEPTH = 1024
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_op_empty,
    input  logic [$clog2(LINE_DEPTH)-1:0]       i_op_addr,
    input  logic [boxf_pkg::PIX_BITS-1:0]       i_op_pix,
    input  boxf_pkg::t_op_ctl                   i_op_ctl,
    output logic                                o_op_pop,
    output logic                                o_empty,
    input  logic                                i_pop,
    output logic [boxf_pkg::PIX_BITS-1:0]       o_pixel_out,
    output logic                                o_frame_last
);

    localparam int CB    = $clog2(LINE_DEPTH);
    localparam int PB    = boxf_pkg::PIX_BITS;
    localparam int CSB   = boxf_pkg::COLSUM_BITS;
    localparam int SB    = boxf_pkg::SUM_BITS;
    localparam int RCB   = boxf_pkg::RECIP_BITS;
    localparam int PRODW = SB + RCB;
    localparam int CNTW  = $clog2(boxf_pkg::OUT_DEPTH+1);
    localparam int CRW   = CNTW + 1;

    function automatic logic [CSB-1:0] col_sum(input logic [PB-1:0] t,
                                               input logic [PB-1:0] m,
                                               input logic [PB-1:0] b,
                                               input logic ut,
                                               input logic ub);
        logic [CSB-1:0] s;
        s = CSB'(m);
        if (ut) begin
            s = s + CSB'(t);
        end
        if (ub) begin
            s = s + CSB'(b);
        end
        return s;
    endfunction

    logic                   r_s1_v;
    logic [CB-1:0]          r_s1_addr;
    logic [PB-1:0]          r_s1_pix;
    boxf_pkg::t_op_ctl      r_s1_ctl;

    logic                   r_wr_v;
    logic [CB-1:0]          r_wr_addr;
    logic [2*PB-1:0]        r_wr_data;
    logic [2*PB-1:0]        w_rd, col_pair;

    logic [PB-1:0]          r_win_old [3];
    logic [PB-1:0]          r_win_new [3];
    logic [PB-1:0]          col_new [3];

    logic                   r_s2_v, r_s2_last;
    logic [CSB-1:0]         r_s2_sum_l, r_s2_sum_c, r_s2_sum_r;
    logic [RCB-1:0]         r_s2_recip;
    logic [CSB-1:0]         n_sum_l, n_sum_c, n_sum_r;
    logic [1:0]             n_rows, n_cols;

    logic                   r_s3_v, r_s3_last;
    logic [SB-1:0]          r_s3_sum;
    logic [RCB-1:0]         r_s3_recip;
    logic [PRODW-1:0]       w_prod;

    logic                   r_s4_v, r_s4_last;
    logic [PB-1:0]          r_s4_pix;

    logic                   w_out_full;
    logic [CNTW-1:0]        w_out_count;
    logic [2:0]             inflight;
    logic [CRW-1:0]         committed;

    always_comb begin
        inflight  = {2'b00, r_s1_v && r_s1_ctl.out_valid} + {2'b00, r_s2_v}
                  + {2'b00, r_s3_v} + {2'b00, r_s4_v};
        committed = CRW'(w_out_count) + CRW'(inflight);
    end

    assign o_op_pop = !i_op_empty && (committed < CRW'(boxf_pkg::OUT_DEPTH));

    boxf_ram #(
        .WIDTH (2*PB),
        .DEPTH (LINE_DEPTH)
    ) u_line (
        .i_clk   (i_clk),
        .i_we    (r_s1_v),
        .i_waddr (r_s1_addr),
        .i_wdata ({col_pair[PB-1:0], r_s1_pix}),
        .i_re    (o_op_pop),
        .i_raddr (i_op_addr),
        .o_rdata (w_rd)
    );

    // The line store reads before it writes, so the word written on the
    // previous edge is taken from the bypass register.
    always_comb begin
        col_pair   = (r_wr_v && (r_wr_addr == r_s1_addr)) ? r_wr_data : w_rd;
        col_new[0] = col_pair[2*PB-1:PB];
        col_new[1] = col_pair[PB-1:0];
        col_new[2] = r_s1_pix;

        n_sum_l = r_s1_ctl.use_left ?
                  col_sum(r_win_old[0], r_win_old[1], r_win_old[2],
                          r_s1_ctl.use_top, r_s1_ctl.use_bot) : '0;
        n_sum_c = col_sum(r_win_new[0], r_win_new[1], r_win_new[2],
                          r_s1_ctl.use_top, r_s1_ctl.use_bot);
        n_sum_r = r_s1_ctl.use_right ?
                  col_sum(col_new[0], col_new[1], col_new[2],
                          r_s1_ctl.use_top, r_s1_ctl.use_bot) : '0;
        n_rows  = 2'd1 + {1'b0, r_s1_ctl.use_top} + {1'b0, r_s1_ctl.use_bot};
        n_cols  = 2'd1 + {1'b0, r_s1_ctl.use_left} + {1'b0, r_s1_ctl.use_right};
    end

    assign w_prod = PRODW'(r_s3_sum) * PRODW'(r_s3_recip);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v <= 1'b0;
            r_wr_v <= 1'b0;
            r_s2_v <= 1'b0;
            r_s3_v <= 1'b0;
            r_s4_v <= 1'b0;
        end else begin
            r_s1_v <= o_op_pop;
            if (r_s1_v) begin
                r_wr_v <= 1'b1;
            end
            r_s2_v <= r_s1_v && r_s1_ctl.out_valid;
            r_s3_v <= r_s2_v;
            r_s4_v <= r_s3_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1_addr <= i_op_addr;
        r_s1_pix  <= i_op_pix;
        r_s1_ctl  <= i_op_ctl;
        if (r_s1_v) begin
            r_wr_addr <= r_s1_addr;
            r_wr_data <= {col_pair[PB-1:0], r_s1_pix};
            for (int k = 0; k < 3; k++) begin
                r_win_old[k] <= r_win_new[k];
                r_win_new[k] <= col_new[k];
            end
        end
        r_s2_last  <= r_s1_ctl.last;
        r_s2_sum_l <= n_sum_l;
        r_s2_sum_c <= n_sum_c;
        r_s2_sum_r <= n_sum_r;
        r_s2_recip <= boxf_pkg::recip(n_rows, n_cols);
        r_s3_last  <= r_s2_last;
        r_s3_sum   <= SB'(r_s2_sum_l) + SB'(r_s2_sum_c) + SB'(r_s2_sum_r);
        r_s3_recip <= r_s2_recip;
        r_s4_last  <= r_s3_last;
        r_s4_pix   <= w_prod[boxf_pkg::RECIP_SHIFT +: PB];
    end

    boxf_fifo #(
        .WIDTH (PB + 1),
        .DEPTH (boxf_pkg::OUT_DEPTH)
    ) u_outq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (r_s4_v),
        .i_data  ({r_s4_last, r_s4_pix}),
        .o_full  (w_out_full),
        .i_pop   (i_pop),
        .o_data  ({o_frame_last, o_pixel_out}),
        .o_empty (o_empty),
        .o_count (w_out_count)
    );

`ifndef SYNTHESIS
    a_outq_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s4_v |-> !w_out_full)
        else $error("Result word reached a full output queue.");

    a_credit_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        committed <= CRW'(boxf_pkg::OUT_DEPTH))
        else $error("More words in flight than output queue entries.");

    a_pipe_flows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s2_v |=> r_s3_v ##1 r_s4_v)
        else $error("Arithmetic pipeline lost a word.");
`endif

endmodule

FILE: rtl/box_filter_3x3_border_adaptive_top.sv
// Path: once the word completing its neighborhood is taken, a result passes the op queue and
// stages s1 to s4 to the output queue, trailing the pixel stream by one row plus one pixel.
// Throughput: one word per cycle while full is low; the line store has separate read and
// write ports. The first drain word of a one-row frame costs an extra front-end advance.
// Reset: synchronous, active low; clears position counters and queues and loads a 640x480
// frame size. The line store is not cleared.
module box_filter_3x3_border_adaptive_top #(
    parameter int MAX_WIDTH = 1024
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                push,
    output logic                                full,
    input  logic                                i_req_type,
    input  logic [boxf_pkg::PIX_BITS-1:0]       i_pixel_in,
    output logic                                empty,
    input  logic                                pop,
    output logic [boxf_pkg::PIX_BITS-1:0]       o_pixel_out,
    output logic                                o_frame_last,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [boxf_pkg::APB_ADDR_BITS-1:0]  paddr,
    input  logic [boxf_pkg::APB_DATA_BITS-1:0]  pwdata,
    output logic [boxf_pkg::APB_DATA_BITS-1:0]  prdata,
    output logic                                pready
);

    localparam int COL_BITS = $clog2(MAX_WIDTH);
    localparam int FWB      = boxf_pkg::FW_BITS;
    localparam int FHB      = boxf_pkg::FH_BITS;
    localparam int HB       = boxf_pkg::HL_BITS;
    localparam int PB       = boxf_pkg::PIX_BITS;
    localparam int CMPW     = (COL_BITS + 1 > FWB) ? COL_BITS + 1 : FWB;
    localparam int CTLW     = $bits(boxf_pkg::t_op_ctl);
    localparam int OPW      = COL_BITS + PB + CTLW;

    logic [FWB-1:0]       r_frame_width;
    logic [FHB-1:0]       r_frame_height;
    logic                 w_cfg_wr;
    boxf_pkg::t_reg_idx   w_reg_idx;
    logic [CMPW-1:0]      w_fw_ext;
    logic [COL_BITS-1:0]  w_col_last;
    logic [HB-1:0]        w_row_last;

    logic                 w_op_push, w_opq_full, w_opq_empty, w_op_pop;
    logic [COL_BITS-1:0]  w_op_addr;
    logic [PB-1:0]        w_op_pix;
    boxf_pkg::t_op_ctl    w_op_ctl, w_opq_ctl;
    logic [OPW-1:0]       w_opq_rd;

    assign pready    = 1'b1;
    assign w_reg_idx = boxf_pkg::t_reg_idx'(paddr[2]);
    assign w_cfg_wr  = psel && penable && pwrite && pready;

    always_comb begin
        unique case (w_reg_idx)
            boxf_pkg::REG_FRAME_WIDTH:  prdata = boxf_pkg::APB_DATA_BITS'(r_frame_width);
            boxf_pkg::REG_FRAME_HEIGHT: prdata = boxf_pkg::APB_DATA_BITS'(r_frame_height);
            default:                    prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_width  <= boxf_pkg::FW_RESET;
            r_frame_height <= boxf_pkg::FH_RESET;
        end else if (w_cfg_wr) begin
            unique case (w_reg_idx)
                boxf_pkg::REG_FRAME_WIDTH:  r_frame_width  <= pwdata[FWB-1:0];
                boxf_pkg::REG_FRAME_HEIGHT: r_frame_height <= pwdata[FHB-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        w_fw_ext = CMPW'(r_frame_width);
        if (w_fw_ext == '0) begin
            w_col_last = '0;
        end else if (w_fw_ext > CMPW'(MAX_WIDTH)) begin
            w_col_last = COL_BITS'(MAX_WIDTH - 1);
        end else begin
            w_col_last = COL_BITS'(w_fw_ext - CMPW'(1));
        end

        if (r_frame_height == '0) begin
            w_row_last = '0;
        end else if (r_frame_height > FHB'(boxf_pkg::HEIGHT_LIMIT)) begin
            w_row_last = HB'(boxf_pkg::HEIGHT_LIMIT - 1);
        end else begin
            w_row_last = HB'(r_frame_height - FHB'(1));
        end
    end

    boxf_front #(
        .COL_BITS (COL_BITS)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_restart  (w_cfg_wr),
        .i_col_last (w_col_last),
        .i_row_last (w_row_last),
        .i_push     (push),
        .i_req_type (i_req_type),
        .i_pixel_in (i_pixel_in),
        .o_full     (full),
        .o_op_push  (w_op_push),
        .o_op_addr  (w_op_addr),
        .o_op_pix   (w_op_pix),
        .o_op_ctl   (w_op_ctl),
        .i_op_full  (w_opq_full)
    );

    boxf_fifo #(
        .WIDTH (OPW),
        .DEPTH (boxf_pkg::OP_DEPTH)
    ) u_opq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_op_push),
        .i_data  ({w_op_addr, w_op_pix, w_op_ctl}),
        .o_full  (w_opq_full),
        .i_pop   (w_op_pop),
        .o_data  (w_opq_rd),
        .o_empty (w_opq_empty),
        .o_count ()
    );

    assign w_opq_ctl = w_opq_rd[CTLW-1:0];

    boxf_back #(
        .LINE_DEPTH (MAX_WIDTH)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_op_empty   (w_opq_empty),
        .i_op_addr    (w_opq_rd[OPW-1 -: COL_BITS]),
        .i_op_pix     (w_opq_rd[CTLW +: PB]),
        .i_op_ctl     (w_opq_ctl),
        .o_op_pop     (w_op_pop),
        .o_empty      (empty),
        .i_pop        (pop),
        .o_pixel_out  (o_pixel_out),
        .o_frame_last (o_frame_last)
    );

endmodule

FILE: dv/testbench.sv
`timescale 1ns / 100ps

module testbench;
    import boxf_pkg::*;

    localparam int LINE_DEPTH = 1024;
    localparam logic REQ_PIXEL = 1'b0;
    localparam logic REQ_DRAIN = 1'b1;

    typedef struct packed {
        logic [PIX_BITS-1:0] pixel;
        logic                last;
    } t_smoothed;

    logic                     i_clk = 1'b0;
    logic                     i_rst_n = 1'b0;
    logic                     push = 1'b0;
    logic                     full;
    logic                     i_req_type = 1'b0;
    logic [PIX_BITS-1:0]      i_pixel_in = '0;
    logic                     empty;
    logic                     pop = 1'b0;
    logic [PIX_BITS-1:0]      o_pixel_out;
    logic                     o_frame_last;
    logic                     psel = 1'b0;
    logic                     penable = 1'b0;
    logic                     pwrite = 1'b0;
    logic [APB_ADDR_BITS-1:0] paddr = '0;
    logic [APB_DATA_BITS-1:0] pwdata = '0;
    logic [APB_DATA_BITS-1:0] prdata;
    logic                     pready;

    box_filter_3x3_border_adaptive_top dut (.*);

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Shadow of the block: frame size registers, line stores, window and counters.
    logic [FW_BITS-1:0]  frame_w_reg;
    logic [FH_BITS-1:0]  frame_h_reg;
    logic [PIX_BITS-1:0] upper_line [LINE_DEPTH];
    logic [PIX_BITS-1:0] mid_line [LINE_DEPTH];
    logic [PIX_BITS-1:0] nbr_cols [6];
    int unsigned         col_pos;
    int unsigned         row_pos;
    int unsigned         pending_px;

    t_smoothed   smoothed_q [$];
    int unsigned mismatches = 0;
    int unsigned words_sent = 0;
    int unsigned effective_words = 0;
    int unsigned results_checked = 0;
    int unsigned frames_done = 0;
    int unsigned send_idle_pct = 0;
    int unsigned stall_pct = 0;

    function automatic int unsigned active_width();
        if (frame_w_reg == 0) return 1;
        if (frame_w_reg > LINE_DEPTH) return LINE_DEPTH;
        return frame_w_reg;
    endfunction

    function automatic int unsigned active_height();
        if (frame_h_reg == 0) return 1;
        if (frame_h_reg > HEIGHT_LIMIT) return HEIGHT_LIMIT;
        return frame_h_reg;
    endfunction

    function automatic void restart_frame();
        col_pos = 0;
        row_pos = 0;
        pending_px = 0;
        foreach (nbr_cols[k]) nbr_cols[k] = '0;
    endfunction

    function automatic void reset_shadow();
        frame_w_reg = FW_RESET;
        frame_h_reg = FH_RESET;
        foreach (upper_line[i]) begin
            upper_line[i] = '0;
            mid_line[i] = '0;
        end
        restart_frame();
    endfunction

    // Shifts one column into the window; returns 1 when a neighborhood center completes.
    function automatic bit slide_window(input logic [PIX_BITS-1:0] v,
                                        output logic [PIX_BITS-1:0] mean);
        int unsigned w, h, c, r, idx, rc, cc, total, n_rows, n_cols;
        logic [PIX_BITS-1:0] fresh [3];
        bit has_right, hit, use_top, use_bot, use_left, use_right, row_ok;
        w = active_width();
        h = active_height();
        c = col_pos;
        r = row_pos;
        idx = c % LINE_DEPTH;
        fresh[0] = upper_line[idx];
        fresh[1] = mid_line[idx];
        fresh[2] = v;
        hit = 0;
        has_right = 0;
        rc = 0;
        cc = 0;
        mean = '0;
        if (c >= 1) begin
            if (r >= 1 && r - 1 < h) begin
                hit = 1;
                rc = r - 1;
                cc = c - 1;
                has_right = 1;
            end
        end else if (r >= 2 && r - 2 < h) begin
            hit = 1;
            rc = r - 2;
            cc = w - 1;
        end
        if (hit) begin
            use_top = rc > 0;
            use_bot = rc + 1 < h;
            use_left = cc > 0;
            use_right = has_right && (cc + 1 < w);
            total = 0;
            n_rows = 0;
            for (int k = 0; k < 3; k++) begin
                row_ok = (k == 1) || (k == 0 && use_top) || (k == 2 && use_bot);
                if (row_ok) begin
                    n_rows++;
                    total += nbr_cols[3 + k];
                    if (use_left) total += nbr_cols[k];
                    if (use_right) total += fresh[k];
                end
            end
            n_cols = 1 + use_left + use_right;
            mean = PIX_BITS'(total / (n_rows * n_cols));
        end
        upper_line[idx] = fresh[1];
        mid_line[idx] = fresh[2];
        for (int k = 0; k < 3; k++) begin
            nbr_cols[k] = nbr_cols[3 + k];
            nbr_cols[3 + k] = fresh[k];
        end
        c++;
        if (c >= w) begin
            c = 0;
            r++;
        end
        col_pos = c;
        row_pos = r;
        return hit;
    endfunction

    function automatic bit predict_smoothed(input logic req, input logic [PIX_BITS-1:0] pix,
                                            output t_smoothed res);
        logic [PIX_BITS-1:0] mean;
        bit got;
        res = '0;
        if (row_pos < active_height()) begin
            if (req == REQ_DRAIN) return 0;
            pending_px++;
            if (!slide_window(pix, mean)) return 0;
            pending_px--;
            res.pixel = mean;
            return 1;
        end
        if (pending_px == 0) begin
            restart_frame();
            return 0;
        end
        got = slide_window('0, mean);
        if (!got) got = slide_window('0, mean);
        if (!got) begin
            restart_frame();
            return 0;
        end
        pending_px--;
        res.pixel = mean;
        res.last = (pending_px == 0);
        if (pending_px == 0) restart_frame();
        return 1;
    endfunction

    function automatic logic [PIX_BITS-1:0] next_pixel();
        case ($urandom_range(7))
            0: return '0;
            1: return '1;
            default: return PIX_BITS'($urandom_range(255));
        endcase
    endfunction

    task automatic flag_mismatch(input string msg);
        mismatches++;
        if (mismatches <= 10) $display("%s", msg);
    endtask

    always @(posedge i_clk) begin
        t_smoothed want;
        if (i_rst_n && pop && empty === 1'b0) begin
            if (smoothed_q.size() == 0) begin
                flag_mismatch($sformatf("unexpected word: pixel %0d last %0b",
                                        o_pixel_out, o_frame_last));
            end else begin
                want = smoothed_q.pop_front();
                results_checked++;
                if (o_pixel_out !== want.pixel)
                    flag_mismatch($sformatf("pixel_out: expected %0d, got %0d",
                                            want.pixel, o_pixel_out));
                if (o_frame_last !== want.last)
                    flag_mismatch($sformatf("frame_last: expected %0b, got %0b",
                                            want.last, o_frame_last));
            end
        end
        pop <= ($urandom_range(99) >= stall_pct);
    end

    task automatic set_idling(input int unsigned send_pct, input int unsigned recv_pct);
        send_idle_pct = send_pct;
        stall_pct = recv_pct;
    endtask

    task automatic send_word(input logic req, input logic [PIX_BITS-1:0] pix);
        t_smoothed res;
        while ($urandom_range(99) < send_idle_pct) begin
            push <= 1'b0;
            @(posedge i_clk);
        end
        push <= 1'b1;
        i_req_type <= req;
        i_pixel_in <= pix;
        @(posedge i_clk);
        while (full !== 1'b0) @(posedge i_clk);
        words_sent++;
        if (req == REQ_PIXEL || row_pos >= active_height()) effective_words++;
        if (predict_smoothed(req, pix, res)) smoothed_q.push_back(res);
    endtask

    task automatic hold_until_drained();
        push <= 1'b0;
        @(posedge i_clk);
        while (smoothed_q.size() != 0) @(posedge i_clk);
        repeat (16) @(posedge i_clk);
    endtask

    task automatic write_frame_reg(input t_reg_idx idx, input logic [APB_DATA_BITS-1:0] value);
        logic [APB_DATA_BITS-1:0] want;
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        if (idx == REG_FRAME_WIDTH) begin
            frame_w_reg = value[FW_BITS-1:0];
            want = APB_DATA_BITS'(frame_w_reg);
        end else begin
            frame_h_reg = value[FH_BITS-1:0];
            want = APB_DATA_BITS'(frame_h_reg);
        end
        restart_frame();
        @(posedge i_clk);
        psel <= 1'b1;
        pwrite <= 1'b0;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        if (prdata !== want)
            flag_mismatch($sformatf("register %s readback: expected %0d, got %0d",
                                    idx.name(), want, prdata));
    endtask

    task automatic write_frame_size(input int unsigned w, input int unsigned h);
        hold_until_drained();
        write_frame_reg(REG_FRAME_WIDTH, w);
        write_frame_reg(REG_FRAME_HEIGHT, h);
    endtask

    task automatic stream_pixels(input int unsigned count, input int unsigned noise_pct);
        for (int unsigned i = 0; i < count; i++) begin
            if ($urandom_range(99) < noise_pct) send_word(REQ_DRAIN, next_pixel());
            send_word(REQ_PIXEL, next_pixel());
        end
    endtask

    // Pixel requests mixed into the drain are taken by the block as drain words, with a zero pixel.
    task automatic drain_frame(input int unsigned noise_pct);
        while (row_pos != 0 || col_pos != 0)
            send_word(($urandom_range(99) < noise_pct) ? REQ_PIXEL : REQ_DRAIN, next_pixel());
        frames_done++;
    endtask

    task automatic test_line_store_prime();
        set_idling(0, 0);
        write_frame_size(2047, 2);
        stream_pixels(active_width() * active_height(), 0);
        drain_frame(0);
    endtask

    task automatic test_directed_extremes();
        set_idling(0, 0);
        write_frame_size(3, 3);
        for (int i = 0; i < 9; i++) begin
            if (i == 4) send_word(REQ_DRAIN, 8'h00);
            send_word(REQ_PIXEL, 8'hFF);
        end
        send_word(REQ_PIXEL, 8'h5A);
        drain_frame(0);
        write_frame_size(0, 0);
        send_word(REQ_PIXEL, 8'hFF);
        drain_frame(0);
        write_frame_size(4, 1);
        send_word(REQ_PIXEL, 8'h00);
        send_word(REQ_PIXEL, 8'hFF);
        send_word(REQ_PIXEL, 8'h00);
        send_word(REQ_PIXEL, 8'hFF);
        drain_frame(0);
    endtask

    task automatic test_frame_abort();
        set_idling(56, 0);
        write_frame_size(5, 4);
        stream_pixels(8, 0);
        hold_until_drained();
        write_frame_reg(REG_FRAME_HEIGHT, 4);
        send_word(REQ_DRAIN, 8'h00);
        stream_pixels(20, 0);
        drain_frame(0);
    endtask

    task automatic test_tall_column();
        set_idling(11, 11);
        write_frame_size(1, 8191);
        stream_pixels(active_width() * active_height(), 3);
        drain_frame(20);
    endtask

    task automatic random_frame(input bit resize);
        int unsigned w, h, pick, pixels;
        if (resize) begin
            pick = $urandom_range(39);
            if (pick == 0) begin
                w = $urandom_range(2047, 1024);
                h = $urandom_range(2);
            end else if (pick == 1) begin
                w = $urandom_range(1);
                h = $urandom_range(40);
            end else begin
                w = $urandom_range(16, 2);
                h = $urandom_range(8);
            end
            write_frame_size(w, h);
        end
        pixels = active_width() * active_height();
        if ($urandom_range(9) == 0) begin
            stream_pixels($urandom_range(pixels - 1), 5);
            hold_until_drained();
            write_frame_reg(REG_FRAME_WIDTH, frame_w_reg);
        end else begin
            stream_pixels(pixels, 5);
            drain_frame(30);
        end
    endtask

    task automatic test_random_frames();
        int unsigned start;
        int unsigned send_mix [4] = '{0, 56, 0, 11};
        int unsigned stall_mix [4] = '{0, 0, 56, 11};
        for (int ph = 0; ph < 4; ph++) begin
            set_idling(send_mix[ph], stall_mix[ph]);
            start = effective_words;
            random_frame(1'b1);
            while (effective_words - start < 475) random_frame($urandom_range(2) == 0);
        end
    endtask

    initial begin
        int unsigned waited;
        waited = 0;
        reset_shadow();
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_line_store_prime();
        test_directed_extremes();
        test_frame_abort();
        test_tall_column();
        test_random_frames();
        push <= 1'b0;
        while (smoothed_q.size() != 0 && waited < 100000) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (20) @(posedge i_clk);
        if (smoothed_q.size() != 0)
            flag_mismatch($sformatf("%0d smoothed pixels never arrived", smoothed_q.size()));
        $display("Ran %0d frames with %0d input words (%0d not ignored), %0d results checked.",
                 frames_done, words_sent, effective_words, results_checked);
        $display("Sizes spanned one pixel up to 1024 wide and 4096 tall under four idling mixes.");
        if (mismatches == 0) begin
            $display("box_filter_3x3_border_adaptive_top: match");
        end else begin
            $display("box_filter_3x3_border_adaptive_top: mismatch");
        end
        $finish;
    end

    initial begin
        #5ms;
        $display("box_filter_3x3_border_adaptive_top: mismatch");
        $finish;
    end

endmodule

FILE: sim.f
rtl/boxf_pkg.sv
rtl/boxf_ram.sv
rtl/boxf_fifo.sv
rtl/boxf_front.sv
rtl/boxf_back.sv
rtl/box_filter_3x3_border_adaptive_top.sv
dv/testbench.sv
